// File: hw/rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot table package
// Shared types, codes and widths of the periodic and one-shot timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Default number of timer slots.
  localparam int unsigned SlotsDefault = 16;

  // Field widths of the stream beats.
  localparam int unsigned OpW      = 2;
  localparam int unsigned ElapsedW = 32;
  localparam int unsigned DelayW   = 40;
  localparam int unsigned PeriodW  = 40;
  localparam int unsigned TargetW  = 4;
  localparam int unsigned EventW   = 3;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CountW   = 16;

  // Remaining delay is held signed, two bits wider than an added delay.
  localparam int unsigned RemW = 42;

  // The catch-up deficit never exceeds 2^32; it is held in 33 bits.
  localparam int unsigned DefW      = ElapsedW + 1;
  localparam int unsigned DivSteps  = DefW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 24;

  // Operation codes of an input beat.
  typedef enum logic [OpW-1:0] {
    OpTick        = 2'd0,
    OpAddOneshot  = 2'd1,
    OpAddPeriodic = 2'd2,
    OpCancel      = 2'd3
  } op_e;

  // Event codes of a result beat.
  typedef enum logic [EventW-1:0] {
    EvAdded     = 3'd0,
    EvFull      = 3'd1,
    EvCancelled = 3'd2,
    EvWasFree   = 3'd3,
    EvOneshot   = 3'd4,
    EvPeriodic  = 3'd5,
    EvNone      = 3'd6
  } event_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StEval,
    StDiv,
    StDivEnd,
    StPush,
    StFlush
  } state_e;

  // One result, without its last flag.
  typedef struct packed {
    event_e            ev;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] cnt;
  } res_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic                   periodic;
    logic signed [RemW-1:0] delay;
    logic [PeriodW-1:0]     period;
  } entry_t;

endpackage

// File: hw/rtl/periodic_and_oneshot_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Periodic and one-shot timer table
// A table of timer slots kept in a synchronous memory, with add, cancel and
// tick operations and a bit-serial divider for periodic catch-up.
// ----------------------------------------------------------------------------
// The block takes one operation beat at a time and answers with one or more
// result beats, the last of which carries tlast. An add or a cancel is taken
// in the idle state and answered from the flush state. A tick walks the slot
// memory twice, first for one-shot slots and then for periodic ones, with a
// read and an evaluation state per slot and pass (one registered read port).
// A firing one-shot slot adds a push state; a firing periodic slot adds the
// divide, divide-end and push states, as its catch-up count comes from a
// restoring divider that retires one quotient bit per cycle, one per bit of
// the 33-bit deficit. A stalled result output holds the push and flush states
// until it drains. Valid bits live in flip-flops and are cleared by reset at
// once, so there is no clearing pass; the memory contents of a free slot may
// be read during a tick but are never used. Each slot is read, modified and
// written back before the next read, so accesses to one entry never overlap.
// ----------------------------------------------------------------------------
module periodic_and_oneshot_timer_table_unit #(
  parameter int unsigned SLOTS = ptt_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Fields from bit 0 up: operation, elapsed_time, initial_delay,
  // repeat_period, target_slot, zero padding.
  input  logic [ptt_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0 up: event_res, slot_index, fire_count, zero padding.
  output logic [ptt_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RemW = ptt_pkg::RemW;
  localparam int unsigned DefW = ptt_pkg::DefW;
  localparam int unsigned PerW = ptt_pkg::PeriodW;

  // Input field unpacking.
  ptt_pkg::op_e                    in_op;
  logic [ptt_pkg::ElapsedW-1:0]    in_elapsed;
  logic [ptt_pkg::DelayW-1:0]      in_delay;
  logic [PerW-1:0]                 in_period;
  logic [ptt_pkg::TargetW-1:0]     in_target;

  assign in_op      = ptt_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_elapsed = s_axis_tdata[33:2];
  assign in_delay   = s_axis_tdata[73:34];
  assign in_period  = s_axis_tdata[113:74];
  assign in_target  = s_axis_tdata[117:114];

  // Registers.
  ptt_pkg::state_e               state_q, state_d;
  logic [SLOTS-1:0]              valid_q, valid_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic                          pass_q, pass_d;
  logic [ptt_pkg::ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic                          hold_v_q, hold_v_d;
  ptt_pkg::res_t                 hold_q, hold_d;
  ptt_pkg::res_t                 cand_q, cand_d;
  logic [DefW-1:0]               dvd_q, dvd_d;
  logic [PerW-1:0]               rem_q, rem_d;
  logic [PerW-1:0]               div_p_q, div_p_d;
  logic [ptt_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic                          out_v_q, out_v_d;
  ptt_pkg::res_t                 out_q, out_d;
  logic                          out_last_q, out_last_d;

  // Slot memory and its registered read data.
  ptt_pkg::entry_t               mem_q [SLOTS];
  ptt_pkg::entry_t               rd_q;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_addr;
  ptt_pkg::entry_t               wr_data;
  logic                          rd_en;

  // Result output register: free when empty or being drained.
  logic out_free;
  assign out_free = !out_v_q || m_axis_tready;

  // Lowest free slot.
  logic            free_found;
  logic [IdxW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // Cancel target check.
  logic            tgt_in_range;
  logic [IdxW-1:0] tgt_idx;
  logic            tgt_valid;

  assign tgt_in_range = {3'b000, in_target} < 7'(SLOTS);
  assign tgt_idx      = IdxW'(in_target);
  assign tgt_valid    = tgt_in_range && valid_q[tgt_idx];

  // Evaluation of the slot just read.
  logic signed [RemW-1:0] new_delay;
  logic [RemW-1:0]        neg_delay;
  logic                   slot_match;
  logic                   slot_fires;

  assign new_delay  = rd_q.delay - $signed({{(RemW - ptt_pkg::ElapsedW){1'b0}}, elapsed_q});
  assign neg_delay  = RemW'(0) - new_delay;
  assign slot_match = valid_q[idx_q] && (rd_q.periodic == pass_q);
  assign slot_fires = new_delay[RemW-1] || (new_delay == '0);

  // One restoring division step.
  logic [PerW:0] rem_sh;
  logic          div_ge;
  logic [PerW:0] rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DefW-1]};
  assign div_ge  = rem_sh >= {1'b0, div_p_q};
  assign rem_sub = rem_sh - {1'b0, div_p_q};

  // Catch-up result: new delay is period minus remainder, count is quotient
  // plus one, saturated.
  logic [PerW-1:0]            catch_delay;
  logic [ptt_pkg::CountW-1:0] catch_cnt;

  assign catch_delay = div_p_q - rem_q;
  assign catch_cnt   = (dvd_q >= DefW'(65535)) ? 16'hFFFF : 16'(dvd_q + DefW'(1));

  // Move on to the next slot, the next pass or the final flush.
  ptt_pkg::state_e adv_state;
  logic [IdxW-1:0] adv_idx;
  logic            adv_pass;

  always_comb begin
    adv_state = ptt_pkg::StRead;
    adv_idx   = idx_q + IdxW'(1);
    adv_pass  = pass_q;
    if (idx_q == IdxW'(SLOTS - 1)) begin
      adv_idx = '0;
      if (!pass_q) begin
        adv_pass = 1'b1;
      end else begin
        adv_state = ptt_pkg::StFlush;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptt_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          state_d = (in_op == ptt_pkg::OpTick) ? ptt_pkg::StRead : ptt_pkg::StFlush;
        end
      end
      ptt_pkg::StRead: begin
        state_d = ptt_pkg::StEval;
      end
      ptt_pkg::StEval: begin
        if (!slot_match || !slot_fires) begin
          state_d = adv_state;
        end else if (!pass_q) begin
          state_d = ptt_pkg::StPush;
        end else begin
          state_d = ptt_pkg::StDiv;
        end
      end
      ptt_pkg::StDiv: begin
        if (cnt_q == ptt_pkg::DivCntW'(ptt_pkg::DivSteps - 1)) begin
          state_d = ptt_pkg::StDivEnd;
        end
      end
      ptt_pkg::StDivEnd: begin
        state_d = ptt_pkg::StPush;
      end
      ptt_pkg::StPush: begin
        if (!hold_v_q || out_free) begin
          state_d = adv_state;
        end
      end
      ptt_pkg::StFlush: begin
        if (out_free) begin
          state_d = ptt_pkg::StIdle;
        end
      end
      default: begin
        state_d = ptt_pkg::StIdle;
      end
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    s_axis_tready = 1'b0;
    valid_d    = valid_q;
    idx_d      = idx_q;
    pass_d     = pass_q;
    elapsed_d  = elapsed_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    cand_d     = cand_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    div_p_d    = div_p_q;
    cnt_d      = cnt_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_d      = out_q;
    out_last_d = out_last_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_q;
    rd_en      = 1'b0;

    case (state_q)
      ptt_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (in_op)
            ptt_pkg::OpAddOneshot, ptt_pkg::OpAddPeriodic: begin
              hold_v_d = 1'b1;
              if (free_found) begin
                wr_en            = 1'b1;
                wr_addr          = free_idx;
                wr_data.periodic = (in_op == ptt_pkg::OpAddPeriodic);
                wr_data.delay    = $signed({2'b00, in_delay});
                if (in_op == ptt_pkg::OpAddPeriodic) begin
                  // A zero period is kept as one so that catch-up ends.
                  wr_data.period = (in_period == '0) ? PerW'(1) : in_period;
                end else begin
                  wr_data.period = '0;
                end
                valid_d[free_idx] = 1'b1;
                hold_d = '{ev: ptt_pkg::EvAdded, slot: 4'(free_idx), cnt: '0};
              end else begin
                hold_d = '{ev: ptt_pkg::EvFull, slot: '0, cnt: '0};
              end
            end
            ptt_pkg::OpCancel: begin
              hold_v_d = 1'b1;
              if (tgt_valid) begin
                valid_d[tgt_idx] = 1'b0;
                hold_d = '{ev: ptt_pkg::EvCancelled, slot: in_target, cnt: '0};
              end else begin
                hold_d = '{ev: ptt_pkg::EvWasFree, slot: in_target, cnt: '0};
              end
            end
            default: begin
              elapsed_d = in_elapsed;
              idx_d     = '0;
              pass_d    = 1'b0;
            end
          endcase
        end
      end
      ptt_pkg::StRead: begin
        rd_en = 1'b1;
      end
      ptt_pkg::StEval: begin
        if (!slot_match) begin
          idx_d  = adv_idx;
          pass_d = adv_pass;
        end else if (!slot_fires) begin
          // Still pending: write the reduced delay back.
          wr_en         = 1'b1;
          wr_data.delay = new_delay;
          idx_d         = adv_idx;
          pass_d        = adv_pass;
        end else if (!pass_q) begin
          valid_d[idx_q] = 1'b0;
          cand_d = '{ev: ptt_pkg::EvOneshot, slot: 4'(idx_q), cnt: 16'd1};
        end else begin
          dvd_d   = neg_delay[DefW-1:0];
          rem_d   = '0;
          div_p_d = rd_q.period;
          cnt_d   = '0;
        end
      end
      ptt_pkg::StDiv: begin
        dvd_d = {dvd_q[DefW-2:0], div_ge};
        rem_d = div_ge ? rem_sub[PerW-1:0] : rem_sh[PerW-1:0];
        cnt_d = cnt_q + ptt_pkg::DivCntW'(1);
      end
      ptt_pkg::StDivEnd: begin
        wr_en            = 1'b1;
        wr_data.periodic = 1'b1;
        wr_data.delay    = $signed({2'b00, catch_delay});
        wr_data.period   = div_p_q;
        cand_d = '{ev: ptt_pkg::EvPeriodic, slot: 4'(idx_q), cnt: catch_cnt};
      end
      ptt_pkg::StPush: begin
        // The held result is sent only once a later one proves it not final.
        if (!hold_v_q) begin
          hold_v_d = 1'b1;
          hold_d   = cand_q;
          idx_d    = adv_idx;
          pass_d   = adv_pass;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = hold_q;
          out_last_d = 1'b0;
          hold_d     = cand_q;
          idx_d      = adv_idx;
          pass_d     = adv_pass;
        end
      end
      ptt_pkg::StFlush: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = hold_v_q ? hold_q : '{ev: ptt_pkg::EvNone, slot: '0, cnt: '0};
          out_last_d = 1'b1;
          hold_v_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ptt_pkg::StIdle;
      valid_q  <= '0;
      idx_q    <= '0;
      pass_q   <= 1'b0;
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      idx_q    <= idx_d;
      pass_q   <= pass_d;
      hold_v_q <= hold_v_d;
      cnt_q    <= cnt_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    elapsed_q  <= elapsed_d;
    hold_q     <= hold_d;
    cand_q     <= cand_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    div_p_q    <= div_p_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // Slot memory with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Output beat.
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_q.cnt, out_q.slot, out_q.ev};

`ifndef SYNTHESIS
  // Nothing is left held once the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptt_pkg::StIdle) |-> !hold_v_q)
    else $error("held result left over in idle");

  // The divider remainder always stays below the period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptt_pkg::StDiv || state_q == ptt_pkg::StDivEnd) |-> (rem_q < div_p_q))
    else $error("divider remainder not below period");

  // A one-shot firing always reports a count of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] == ptt_pkg::EvOneshot))
      |-> (m_axis_tdata[22:7] == 16'd1))
    else $error("one-shot firing with a count other than one");

  // A nothing-fired result is always the final beat of its tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] == ptt_pkg::EvNone)) |-> m_axis_tlast)
    else $error("nothing-fired result without tlast");
`endif

endmodule
